// ----- rtl/oal_pkg.sv -----
// shared constants, codes and control structs of the ordered array list
package oal_pkg;

	// list geometry
	localparam int CAPACITY   = 64;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	// stream field widths
	localparam int KIND_W = 2;
	localparam int POS_W  = 7;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;
	localparam int MIDX_W = 6;
	localparam int ECNT_W = 7;

	// common width for index and count compares
	localparam int CW  = (CNT_W > POS_W) ? CNT_W : POS_W;
	// common width for value conversions
	localparam int DXW = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;

	// input word layout, zero filled to whole bytes
	localparam int IN_RAW_W  = POS_W + VAL_W;
	localparam int IN_DATA_W = ((IN_RAW_W + 7) / 8) * 8;
	localparam int VAL_LSB   = POS_W;

	// output word layout
	localparam int OUT_RAW_W  = STAT_W + 1 + MIDX_W + VAL_W + ECNT_W;
	localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

	typedef enum logic [KIND_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_ERASE  = 2'd1,
		REQ_FIND   = 2'd2,
		REQ_READ   = 2'd3
	} req_e_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_e_t;

	// memory read address sources
	typedef enum logic [2:0] {
		RD_CNT_M1,
		RD_POS,
		RD_POS_P1,
		RD_ZERO,
		RD_PTR_DN,
		RD_PTR_UP
	} rd_sel_t;

	// memory write address and data sources
	typedef enum logic [1:0] {
		WR_UP,
		WR_DN,
		WR_VAL
	} wr_sel_t;

	// controller to datapath
	typedef struct packed {
		logic    req_ld;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    res_init;
		logic    res_found;
		logic    res_data;
		logic    out_ld;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		req_e_t kind;
		logic   err;
		logic   pos_at_tail;
		logic   pos_last;
		logic   cnt_zero;
		logic   ptr_at_pos;
		logic   ptr_at_last;
		logic   match;
		logic   out_free;
	} sts_t;

endpackage

// ----- rtl/oal_ram.sv -----
// generic single write port, single read port ram with registered read
module oal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/oal_ctrl.sv -----
// request sequencer of the ordered array list
module oal_ctrl
	import oal_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		IDLE,
		CHECK,
		SHIFT_UP,
		PUT,
		SHIFT_DN,
		SCAN,
		RD_WAIT,
		FIN
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == IDLE);

	// next state and command decode
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			IDLE: begin
				if (in_valid) begin
					cmd.req_ld = 1'b1;
					state_d    = CHECK;
				end
			end
			CHECK: begin
				cmd.res_init = 1'b1;
				if (sts.err) begin
					state_d = FIN;
				end else begin
					unique case (sts.kind)
						REQ_INSERT: begin
							if (sts.pos_at_tail) begin
								cmd.wr_en   = 1'b1;
								cmd.wr_sel  = WR_VAL;
								cmd.cnt_inc = 1'b1;
								state_d     = FIN;
							end else begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = RD_CNT_M1;
								state_d    = SHIFT_UP;
							end
						end
						REQ_ERASE: begin
							if (sts.pos_last) begin
								cmd.cnt_dec = 1'b1;
								state_d     = FIN;
							end else begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = RD_POS_P1;
								state_d    = SHIFT_DN;
							end
						end
						REQ_FIND: begin
							if (sts.cnt_zero) begin
								state_d = FIN;
							end else begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = RD_ZERO;
								state_d    = SCAN;
							end
						end
						REQ_READ: begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_POS;
							state_d    = RD_WAIT;
						end
						default: state_d = FIN;
					endcase
				end
			end
			SHIFT_UP: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_UP;
				if (sts.ptr_at_pos) begin
					state_d = PUT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PTR_DN;
				end
			end
			PUT: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_VAL;
				cmd.cnt_inc = 1'b1;
				state_d     = FIN;
			end
			SHIFT_DN: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_DN;
				if (sts.ptr_at_last) begin
					cmd.cnt_dec = 1'b1;
					state_d     = FIN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PTR_UP;
				end
			end
			SCAN: begin
				if (sts.match) begin
					cmd.res_found = 1'b1;
					state_d       = FIN;
				end else if (sts.ptr_at_last) begin
					state_d = FIN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PTR_UP;
				end
			end
			RD_WAIT: begin
				cmd.res_data = 1'b1;
				state_d      = FIN;
			end
			FIN: begin
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = IDLE;
				end
			end
			default: state_d = IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	// an accepted word is always checked in the next cycle
	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == CHECK))
		else $error("accepted word not followed by check");

	// shift and scan steps consume data read in the previous cycle
	a_read_before_use: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SHIFT_UP || state_q == SHIFT_DN || state_q == SCAN
			|| state_q == RD_WAIT) |-> $past(cmd.rd_en))
		else $error("memory data used without a read in the previous cycle");

	// the result register is only loaded when it is free
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> sts.out_free)
		else $error("result overwritten before delivery");

	// count changes at most by one per request and never both ways at once, and no write while idle
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.cnt_inc && cmd.cnt_dec) && !(cmd.wr_en && state_q == IDLE))
		else $error("conflicting count update or write while idle");
`endif

endmodule

// ----- rtl/oal_dp.sv -----
// entry storage, count, pointer and result registers of the ordered array list
module oal_dp
	import oal_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic [IN_DATA_W-1:0]  in_tdata,
	input  logic [KIND_W-1:0]     in_tuser,
	output logic                  out_tvalid,
	input  logic                  out_tready,
	output logic [OUT_DATA_W-1:0] out_tdata
);

	// request registers
	req_e_t                req_kind_q;
	logic [POS_W-1:0]      req_pos_q;
	logic [DATA_WIDTH-1:0] req_val_q;

	logic [CNT_W-1:0]      count_q;
	logic [IDX_W-1:0]      ptr_q;

	// working result
	status_e_t             res_status_q;
	logic                  res_found_q;
	logic [IDX_W-1:0]      res_midx_q;
	logic [DATA_WIDTH-1:0] res_dout_q;

	// output register
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// memory ports
	logic                  rd_en;
	logic [IDX_W-1:0]      rd_addr;
	logic [DATA_WIDTH-1:0] rd_data;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;

	// derived values
	logic [CW-1:0]         pos_ext;
	logic [CW-1:0]         cnt_ext;
	logic [CW-1:0]         pos_p1_ext;
	logic [IDX_W-1:0]      pos_idx;
	logic [CNT_W-1:0]      cnt_m1;
	logic [IDX_W-1:0]      last_idx;
	logic                  full;
	status_e_t             chk_status;
	logic [DXW-1:0]        in_val_ext;
	logic [DXW-1:0]        dout_ext;
	logic [CW-1:0]         midx_ext;
	logic [CW-1:0]         ecnt_ext;

	assign pos_ext    = CW'(req_pos_q);
	assign cnt_ext    = CW'(count_q);
	assign pos_p1_ext = pos_ext + CW'(1);
	assign pos_idx    = pos_ext[IDX_W-1:0];
	assign cnt_m1     = count_q - CNT_W'(1);
	assign last_idx   = cnt_m1[IDX_W-1:0];
	assign full       = (count_q == CNT_W'(CAPACITY));
	assign in_val_ext = DXW'(in_tdata[VAL_LSB +: VAL_W]);

	// request checks
	always_comb begin
		chk_status = ST_OK;
		case (req_kind_q)
			REQ_INSERT: begin
				if (pos_ext > cnt_ext) begin
					chk_status = ST_RANGE;
				end else if (full) begin
					chk_status = ST_FULL;
				end
			end
			REQ_ERASE, REQ_READ: begin
				if (pos_ext >= cnt_ext) begin
					chk_status = ST_RANGE;
				end
			end
			default: chk_status = ST_OK;
		endcase
	end

	// status to controller
	always_comb begin
		sts.kind        = req_kind_q;
		sts.err         = (chk_status != ST_OK);
		sts.pos_at_tail = (pos_ext == cnt_ext);
		sts.pos_last    = (pos_p1_ext == cnt_ext);
		sts.cnt_zero    = (count_q == '0);
		sts.ptr_at_pos  = (ptr_q == pos_idx);
		sts.ptr_at_last = (ptr_q == last_idx);
		sts.match       = (rd_data == req_val_q);
		sts.out_free    = !out_valid_q || out_tready;
	end

	// read address select
	always_comb begin
		rd_en = cmd.rd_en;
		unique case (cmd.rd_sel)
			RD_CNT_M1: rd_addr = last_idx;
			RD_POS:    rd_addr = pos_idx;
			RD_POS_P1: rd_addr = pos_idx + IDX_W'(1);
			RD_ZERO:   rd_addr = '0;
			RD_PTR_DN: rd_addr = ptr_q - IDX_W'(1);
			RD_PTR_UP: rd_addr = ptr_q + IDX_W'(1);
			default:   rd_addr = '0;
		endcase
	end

	// write address and data select
	always_comb begin
		wr_en = cmd.wr_en;
		unique case (cmd.wr_sel)
			WR_UP: begin
				wr_addr = ptr_q + IDX_W'(1);
				wr_data = rd_data;
			end
			WR_DN: begin
				wr_addr = ptr_q - IDX_W'(1);
				wr_data = rd_data;
			end
			WR_VAL: begin
				wr_addr = pos_idx;
				wr_data = req_val_q;
			end
			default: begin
				wr_addr = pos_idx;
				wr_data = req_val_q;
			end
		endcase
	end

	oal_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// request, pointer and working result registers
	always_ff @(posedge clk) begin
		if (cmd.req_ld) begin
			req_kind_q <= req_e_t'(in_tuser);
			req_pos_q  <= in_tdata[POS_W-1:0];
			req_val_q  <= in_val_ext[DATA_WIDTH-1:0];
		end
		if (cmd.rd_en) begin
			ptr_q <= rd_addr;
		end
		if (cmd.res_init) begin
			res_status_q <= chk_status;
			res_found_q  <= 1'b0;
			res_midx_q   <= '0;
			res_dout_q   <= '0;
		end
		if (cmd.res_found) begin
			res_found_q <= 1'b1;
			res_midx_q  <= ptr_q;
		end
		if (cmd.res_data) begin
			res_dout_q <= rd_data;
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.cnt_dec) begin
			count_q <= cnt_m1;
		end
	end

	assign dout_ext = DXW'(res_dout_q);
	assign midx_ext = CW'(res_midx_q);
	assign ecnt_ext = CW'(count_q);

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_data_q <= OUT_DATA_W'({ecnt_ext[ECNT_W-1:0], dout_ext[VAL_W-1:0],
				midx_ext[MIDX_W-1:0], res_found_q, res_status_q});
		end
	end

	assign out_tvalid = out_valid_q;
	assign out_tdata  = out_data_q;

endmodule

// ----- rtl/ordered_array_list.sv -----
// top level of the ordered array list
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid / tready        tuser = req_type, tdata = position, data_in
//  m_axis    out  tvalid / tready        tdata = status, found, match_index,
//                                                data_out, entry_count
//
// one request at a time; entries sit in a ram with a single read port, so every
// shifted or scanned entry takes its own read of that port: insert at p shifts
// the entries from p up to count - 1 (none when p equals count), erase at p
// shifts the entries above p down, find scans from index 0 up to the first match
// (all entries without one), read fetches one entry, and a rejected request reads none.
// reset clears the count and the output valid; no clearing pass is needed.
// a new word is taken while a result still waits on m_axis; a stalled
// m_axis holds the next result in the sequencer until the register frees.
module ordered_array_list
	import oal_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [6:0] position, [38:7] data_in, [39] zero
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// [1:0] req_type
	input  logic [KIND_W-1:0]     s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [1:0] status, [2] found, [8:3] match_index, [40:9] data_out,
	// [47:41] entry_count
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	cmd_t cmd;
	sts_t sts;

	// sequencer
	oal_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// storage and result path
	oal_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_tdata  (s_axis_tdata),
		.in_tuser  (s_axis_tuser),
		.out_tvalid(m_axis_tvalid),
		.out_tready(m_axis_tready),
		.out_tdata (m_axis_tdata)
	);

endmodule

// ----- dv/ordered_array_list_tb.sv -----
// self-checking testbench for the ordered array list stream block
module ordered_array_list_tb
	import oal_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_REPORTS = 10;
	localparam int DRAIN_WAIT  = 100;
	localparam int HOLD_LEN    = 400;

	// one result word, split into its fields
	typedef struct packed {
		status_e_t           status;
		logic                found;
		logic [MIDX_W-1:0]   match_index;
		logic [VAL_W-1:0]    data_out;
		logic [ECNT_W-1:0]   entry_count;
	} list_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// [6:0] position, [38:7] data_in, [39] zero
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	// [1:0] req_type
	logic [KIND_W-1:0]     s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// [1:0] status, [2] found, [8:3] match_index, [40:9] data_out, [47:41] entry_count
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// shadow copy of the list contents and the results still owed
	logic [VAL_W-1:0] shadow_list[$];
	list_result_t     pending_results[$];

	int mismatch_count = 0;
	int send_idle_pct  = 0;
	int recv_idle_pct  = 0;
	int hold_request   = 0;
	int hold_left      = 0;

	ordered_array_list dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		#10ms;
		$display("Test completed with failures");
		$finish;
	end

	// apply one request to the shadow list and return the result it should give
	function automatic list_result_t apply_request(input req_e_t kind,
			input logic [POS_W-1:0] pos, input logic [VAL_W-1:0] val);
		list_result_t res;
		int p;
		int sz;
		int i;
		res = '0;
		p = int'(pos);
		sz = shadow_list.size();
		case (kind)
			REQ_INSERT: begin
				// range check wins over the full check
				if (p > sz)
					res.status = ST_RANGE;
				else if (sz >= CAPACITY)
					res.status = ST_FULL;
				else
					shadow_list.insert(p, val);
			end
			REQ_ERASE: begin
				if (p >= sz)
					res.status = ST_RANGE;
				else
					shadow_list.delete(p);
			end
			REQ_FIND: begin
				// lowest matching index
				for (i = 0; i < sz; i++) begin
					if (shadow_list[i] == val) begin
						res.found = 1'b1;
						res.match_index = MIDX_W'(i);
						break;
					end
				end
			end
			default: begin
				if (p >= sz)
					res.status = ST_RANGE;
				else
					res.data_out = shadow_list[p];
			end
		endcase
		res.entry_count = ECNT_W'(shadow_list.size());
		return res;
	endfunction

	// data values weighted toward extremes and a small pool of repeats
	function automatic logic [VAL_W-1:0] rand_word();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'h0000_0000;
			4, 5: return VAL_W'($urandom_range(7));
			default: return VAL_W'($urandom);
		endcase
	endfunction

	// offer one word, wait for it to be taken, then record what it should return
	task automatic send_request(input req_e_t kind, input logic [POS_W-1:0] pos,
			input logic [VAL_W-1:0] val);
		list_result_t exp_res;
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= IN_DATA_W'({val, pos});
		do @(posedge clk); while (!s_axis_tready);
		exp_res = apply_request(kind, pos, val);
		pending_results.push_back(exp_res);
	endtask

	// receiver: random stalls, plus a long hold when one is requested
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic void check_field(input string name, input logic [63:0] exp_val,
			input logic [63:0] act_val);
		if (act_val !== exp_val) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("%0t: mismatch in %s: expected %h, got %h", $realtime, name,
					exp_val, act_val);
		end
	endfunction

	// compare each result word with the oldest expectation
	always @(posedge clk) begin
		list_result_t exp_res;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: result word with nothing expected: %h", $realtime,
						m_axis_tdata);
			end else begin
				exp_res = pending_results.pop_front();
				check_field("status", 64'(exp_res.status),
					64'(m_axis_tdata[STAT_W-1:0]));
				check_field("found", 64'(exp_res.found), 64'(m_axis_tdata[STAT_W]));
				check_field("match_index", 64'(exp_res.match_index),
					64'(m_axis_tdata[STAT_W+1 +: MIDX_W]));
				check_field("data_out", 64'(exp_res.data_out),
					64'(m_axis_tdata[STAT_W+1+MIDX_W +: VAL_W]));
				check_field("entry_count", 64'(exp_res.entry_count),
					64'(m_axis_tdata[STAT_W+1+MIDX_W+VAL_W +: ECNT_W]));
			end
		end
	end

	// empty list errors, range errors, pushes at both ends, duplicate finds
	task automatic test_corner_cases();
		send_request(REQ_ERASE, 0, 32'h0);
		send_request(REQ_READ, 0, 32'hffff_ffff);
		send_request(REQ_FIND, 0, 32'h0);
		send_request(REQ_INSERT, 1, 32'h1);
		send_request(REQ_INSERT, 127, 32'h2);
		send_request(REQ_INSERT, 0, 32'h7fff_ffff);
		send_request(REQ_INSERT, 1, 32'h8000_0000);
		send_request(REQ_INSERT, 0, 32'hffff_ffff);
		send_request(REQ_INSERT, 1, 32'h0);
		send_request(REQ_INSERT, 4, 32'h8000_0000);
		send_request(REQ_FIND, 127, 32'h8000_0000);
		send_request(REQ_FIND, 0, 32'h1234_5678);
		send_request(REQ_FIND, 0, 32'hffff_ffff);
		send_request(REQ_READ, 4, 32'h0);
		send_request(REQ_READ, 5, 32'h0);
		send_request(REQ_READ, 64, 32'h0);
		send_request(REQ_ERASE, 5, 32'h0);
		send_request(REQ_ERASE, 4, 32'h0);
		send_request(REQ_ERASE, 0, 32'h0);
		send_request(REQ_READ, 0, 32'h0);
		send_request(REQ_ERASE, 127, 32'hffff_ffff);
		send_request(REQ_INSERT, 64, 32'h5);
		send_request(REQ_FIND, 0, 32'h7fff_ffff);
	endtask

	// fill to capacity, poke the full list, then drain it
	task automatic test_fill_and_drain();
		int sz;
		while (shadow_list.size() < CAPACITY)
			send_request(REQ_INSERT, POS_W'($urandom_range(shadow_list.size())), rand_word());
		send_request(REQ_INSERT, POS_W'(CAPACITY), rand_word());
		send_request(REQ_INSERT, POS_W'(CAPACITY + 1), rand_word());
		send_request(REQ_INSERT, 0, rand_word());
		send_request(REQ_ERASE, POS_W'(CAPACITY), 32'h0);
		send_request(REQ_READ, POS_W'(CAPACITY - 1), 32'h0);
		send_request(REQ_READ, POS_W'(CAPACITY), 32'h0);
		send_request(REQ_FIND, 0, shadow_list[CAPACITY-1]);
		send_request(REQ_FIND, 0, shadow_list[0]);
		while (shadow_list.size() > 0) begin
			sz = shadow_list.size();
			case ($urandom_range(3))
				0: send_request(REQ_READ, POS_W'($urandom_range(sz - 1)), VAL_W'($urandom));
				1: send_request(REQ_FIND, POS_W'($urandom_range(127)),
					shadow_list[$urandom_range(sz - 1)]);
				default: send_request(REQ_ERASE, POS_W'($urandom_range(sz - 1)),
					VAL_W'($urandom));
			endcase
		end
	endtask

	// random mix that drifts between growing and shrinking the list
	task automatic run_random_mix(input int n);
		int sz;
		int r;
		int lo;
		bit grow;
		req_e_t kind;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
		grow = 1'b1;
		repeat (n) begin
			sz = shadow_list.size();
			if (sz == CAPACITY)
				grow = 1'b0;
			else if (sz == 0)
				grow = 1'b1;
			else if ($urandom_range(49) == 0)
				grow = !grow;
			r = $urandom_range(99);
			if (r < (grow ? 50 : 20))
				kind = REQ_INSERT;
			else if (r < 70)
				kind = REQ_ERASE;
			else if (r < 85)
				kind = REQ_FIND;
			else
				kind = REQ_READ;
			// position: mostly legal, sometimes past the end
			if (kind == REQ_FIND) begin
				pos = POS_W'($urandom_range(127));
			end else if ($urandom_range(9) == 0 || (kind != REQ_INSERT && sz == 0)) begin
				lo = (kind == REQ_INSERT) ? sz + 1 : sz;
				pos = POS_W'($urandom_range(127, lo));
			end else if (kind == REQ_INSERT) begin
				pos = POS_W'($urandom_range(sz));
			end else begin
				pos = POS_W'($urandom_range(sz - 1));
			end
			// value: finds mostly look for something present
			if (kind == REQ_FIND && sz > 0 && $urandom_range(9) < 7)
				val = shadow_list[$urandom_range(sz - 1)];
			else if (kind == REQ_INSERT || kind == REQ_FIND)
				val = rand_word();
			else
				val = VAL_W'($urandom);
			send_request(kind, pos, val);
		end
	endtask

	// three idle patterns in turn
	task automatic test_random_traffic();
		send_idle_pct = 34;
		recv_idle_pct = 70;
		run_random_mix(310);
		send_idle_pct = 70;
		recv_idle_pct = 34;
		run_random_mix(310);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random_mix(310);
	endtask

	// long receiver hold while words keep coming, so the input stalls
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 20;
		hold_request = HOLD_LEN;
		wait (hold_left > 0);
		run_random_mix(40);
	endtask

	// main sequence
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 34;
		recv_idle_pct = 70;
		test_corner_cases();
		test_fill_and_drain();
		test_random_traffic();
		test_backpressure();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
